// ----- rtl/core/fq15_pkg.sv -----
// Package with constants, codes and sequencer states of the Q15 FIR filter core.
`timescale 1ns / 1ps

package fq15_pkg;

  localparam int FQ_TAPS = 64;

  localparam int FQ_IDX_W    = 6;
  localparam int FQ_SAMPLE_W = 16;
  localparam int FQ_DATA_W   = 24;

  localparam logic [31:0] FQ_RND   = 32'h0000_4000;
  localparam int          FQ_SHIFT = 15;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } fq_state_t;

endpackage

// ----- rtl/core/fir_filter_q15_core.sv -----
// Top level of the direct-form Q15 FIR filter core with one shared multiply-accumulate unit.
`timescale 1ns / 1ps

// A coefficient load (tuser low) leaves the core ready for the next request. A sample
// (tuser high) keeps s_tready low from its accept until its result is loaded, because one
// multiplier and one accumulator work through the taps at one tap per cycle, fed by one
// read port of each memory, and then wait out the read and multiply registers. A finished
// result waits in the output register while the next request is taken; only the final step
// stalls if it is still held. After reset both memories are cleared with s_tready low.
module fir_filter_q15_core #(
  parameter int TAPS = fq15_pkg::FQ_TAPS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [fq15_pkg::FQ_DATA_W-1:0] s_tdata,   // coef_index[5:0], value[21:6], zero
  input  logic                           s_tuser,   // func
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [fq15_pkg::FQ_SAMPLE_W-1:0] m_tdata  // sample_out[15:0]
);

  import fq15_pkg::*;

  localparam int AW    = $clog2(TAPS);
  localparam int IW    = ((AW > FQ_IDX_W) ? AW : FQ_IDX_W) + 1;
  localparam int ACC_W = 32 + AW;
  localparam logic [AW-1:0] LAST = AW'(TAPS - 1);
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32'sd32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = ACC_W'(-32'sd32768);

  fq_state_t state, state_next;

  logic [FQ_IDX_W-1:0]           coef_index;
  logic signed [FQ_SAMPLE_W-1:0] value;
  logic                          accept;
  logic [IW-1:0]                 idx_ext;

  logic [AW-1:0] cnt, cnt_next;
  logic [AW-1:0] write_pos;
  logic [AW-1:0] rd_ptr;

  logic signed [FQ_SAMPLE_W-1:0] coef_mem  [TAPS];
  logic signed [FQ_SAMPLE_W-1:0] delay_mem [TAPS];
  logic signed [FQ_SAMPLE_W-1:0] coef_q, samp_q;

  logic                          coef_we, delay_we, rd_en;
  logic [AW-1:0]                 coef_waddr, delay_waddr;
  logic signed [FQ_SAMPLE_W-1:0] coef_wdata, delay_wdata;

  logic                    v1, v2;
  logic signed [31:0]      prod;
  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] rounded, shifted;
  logic signed [FQ_SAMPLE_W-1:0] sat;
  logic                    out_load;

  assign coef_index = s_tdata[FQ_IDX_W-1:0];
  assign value      = s_tdata[FQ_IDX_W +: FQ_SAMPLE_W];
  assign accept     = s_tvalid && s_tready;
  assign idx_ext    = IW'(coef_index);

  always_comb begin
    rounded = acc + ACC_W'(FQ_RND);
    shifted = rounded >>> FQ_SHIFT;
    if (shifted > SAT_MAX) begin
      sat = 16'sh7FFF;
    end else if (shifted < SAT_MIN) begin
      sat = 16'sh8000;
    end else begin
      sat = shifted[FQ_SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    s_tready    = 1'b0;
    rd_en       = 1'b0;
    out_load    = 1'b0;
    coef_we     = 1'b0;
    coef_waddr  = idx_ext[AW-1:0];
    coef_wdata  = value;
    delay_we    = 1'b0;
    delay_waddr = write_pos;
    delay_wdata = value;
    case (state)
      ST_CLEAR: begin
        coef_we     = 1'b1;
        coef_waddr  = cnt;
        coef_wdata  = '0;
        delay_we    = 1'b1;
        delay_waddr = cnt;
        delay_wdata = '0;
        cnt_next    = cnt + 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (s_tuser == FUNC_SAMPLE) begin
            delay_we   = 1'b1;
            cnt_next   = '0;
            state_next = ST_MAC;
          end else begin
            coef_we = (idx_ext < IW'(TAPS));
          end
        end
      end
      ST_MAC: begin
        rd_en    = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == LAST) begin
          cnt_next   = '0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1 && !v2) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (coef_we) begin
      coef_mem[coef_waddr] <= coef_wdata;
    end
    if (rd_en) begin
      coef_q <= coef_mem[cnt];
    end
  end

  always_ff @(posedge clk) begin
    if (delay_we) begin
      delay_mem[delay_waddr] <= delay_wdata;
    end
    if (rd_en) begin
      samp_q <= delay_mem[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_pos <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      v1 <= rd_en;
      v2 <= v1;
      if (accept && s_tuser == FUNC_SAMPLE) begin
        write_pos <= (write_pos == LAST) ? '0 : write_pos + 1'b1;
      end
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tuser == FUNC_SAMPLE) begin
      rd_ptr <= write_pos;
      acc    <= '0;
    end else begin
      if (rd_en) begin
        rd_ptr <= (rd_ptr == '0) ? LAST : rd_ptr - 1'b1;
      end
      if (v2) begin
        acc <= acc + ACC_W'(prod);
      end
    end
    if (v1) begin
      prod <= coef_q * samp_q;
    end
    if (out_load) begin
      m_tdata <= sat;
    end
  end

  a_sample_starts_mac: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == FUNC_SAMPLE) |=> (state == ST_MAC))
    else $error("sample accept did not start the tap sweep");

  a_finish_holds: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FINISH && m_tvalid && !m_tready) |=> (state == ST_FINISH))
    else $error("result step left while output still held");

  a_acc_in_sweep: assert property (@(posedge clk) disable iff (rst)
    v2 |-> (state == ST_MAC || state == ST_DRAIN))
    else $error("accumulate outside the tap sweep");

  a_out_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(state) == ST_FINISH))
    else $error("result raised outside the final step");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for the Q15 FIR filter core: predicts each filtered sample and compares.
`timescale 1ns / 1ps

module testbench;
  import fq15_pkg::*;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   s_tvalid;
  logic                   s_tready;
  logic [FQ_DATA_W-1:0]   s_tdata;
  logic                   s_tuser;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [FQ_SAMPLE_W-1:0] m_tdata;

  logic signed [15:0] tap_coef [FQ_TAPS];
  logic signed [15:0] sample_hist [FQ_TAPS];
  logic [5:0]         hist_head;
  logic [15:0]        expected_sample_out [$];

  int error_count;
  bit no_idle;
  int rx_stall;

  fir_filter_q15_core #(.TAPS(FQ_TAPS)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #4 clk = ~clk;

  function automatic int draw_wait();
    int n;
    n = no_idle ? 0 : $urandom_range(0, 13);
    return n;
  endfunction

  // Insert the sample into the history and form the rounded, saturated dot product.
  function automatic logic [15:0] filter_sample(input logic signed [15:0] x);
    longint     acc;
    longint     y;
    logic [5:0] pos;
    int         k;
    sample_hist[hist_head] = x;
    acc = 0;
    for (k = 0; k < FQ_TAPS; k++) begin
      pos = hist_head - 6'(k);
      acc += longint'(tap_coef[6'(k)]) * longint'(sample_hist[pos]);
    end
    hist_head = hist_head + 6'd1;
    y = (acc + 64'sh4000) >>> FQ_SHIFT;
    if (y > 32767) begin
      y = 32767;
    end else if (y < -32768) begin
      y = -32768;
    end
    return 16'(y);
  endfunction

  task automatic send_request(input logic func, input logic [5:0] idx,
                              input logic [15:0] value);
    int gap;
    gap = draw_wait();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= {2'b00, value, idx};
    do @(posedge clk); while (!s_tready);
    if (func == FUNC_LOAD) begin
      tap_coef[idx] = value;
    end else begin
      expected_sample_out.push_back(filter_sample(value));
    end
  endtask

  task automatic load_coef(input logic [5:0] idx, input logic [15:0] value);
    send_request(FUNC_LOAD, idx, value);
  endtask

  task automatic filter_one(input logic [15:0] value);
    send_request(FUNC_SAMPLE, 6'd0, value);
  endtask

  // Drop valid and hold until every predicted sample has come out.
  task automatic pause_until_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_sample_out.size() != 0) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (rx_stall > 0) begin
      m_tready <= 1'b0;
      rx_stall = rx_stall - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_sample_out.size() == 0) begin
        $error("sample_out: no result expected, got %0d", $signed(m_tdata));
        error_count++;
      end else begin
        want = expected_sample_out.pop_front();
        if (m_tdata !== want) begin
          $error("sample_out: expected %0d, got %0d", $signed(want), $signed(m_tdata));
          error_count++;
        end
      end
      rx_stall = draw_wait();
    end
  end

  task automatic test_extreme_values();
    load_coef(6'd0, 16'sd32767);
    filter_one(16'sd32767);
    filter_one(-16'sd32768);
    filter_one(16'sd0);
    load_coef(6'd0, -16'sd32768);
    filter_one(-16'sd32768);
    load_coef(6'd1, -16'sd32768);
    filter_one(16'sd32767);
    filter_one(16'sd32767);
    load_coef(6'd63, 16'sd32767);
    load_coef(6'd0, 16'sd1);
    load_coef(6'd1, 16'sd0);
    filter_one(-16'sd1);
    filter_one(16'sd1);
    load_coef(6'd42, 16'sd16384);
    load_coef(6'd21, -16'sd16384);
    filter_one(16'sd16384);
    filter_one(-16'sd16385);
  endtask

  task automatic test_random_stream(input int count);
    int          i;
    logic [15:0] value;
    for (i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        no_idle = ($urandom_range(0, 2) == 0);
      end
      if ($urandom_range(0, 7) == 0) begin
        case ($urandom_range(0, 3))
          0: value = 16'h8000;
          1: value = 16'h7fff;
          2: value = 16'hffff;
          default: value = 16'h0000;
        endcase
      end else begin
        value = 16'($urandom);
      end
      if ($urandom_range(0, 4) == 0) begin
        if ($urandom_range(0, 3) != 0) begin
          value = 16'($signed(17'($urandom_range(0, 2047))) - 17'sd1024);
        end
        load_coef(6'($urandom_range(0, 63)), value);
      end else begin
        filter_one(value);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    int i;
    for (i = 0; i < FQ_TAPS; i++) begin
      tap_coef[6'(i)]    = '0;
      sample_hist[6'(i)] = '0;
    end
    hist_head   = '0;
    error_count = 0;
    no_idle     = 1'b0;
    rx_stall    = 0;
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    s_tuser     = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extreme_values();
    test_random_stream(340);
    pause_until_drained();
    test_random_stream(340);
    pause_until_drained();

    repeat (FQ_TAPS + 16) @(posedge clk);
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
